>>> rtl/slul_pkg.sv
// ----------------------------------------------------------------------------
// slul_pkg
// Shared constants, types and the lamp bit map of the lamp update limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package slul_pkg;

  // Lamp count default and bit widths
  localparam int LAMPS_DEF   = 10;
  localparam int WORD_W      = 32;
  localparam int TIME_W      = 32;
  localparam int FRAME_W     = 10;
  localparam int INTERVAL_W  = 8;
  localparam int PERIOD_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_ADDR_W  = 1;
  localparam int BIT_SEL_W   = 5;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CHANGE_INTERVAL = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REFRESH_PERIOD  = 1'b1;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 8'd2;
  localparam logic [PERIOD_W-1:0]   PERIOD_RST   = 16'd100;

  // Walk control from the sequencer
  typedef struct packed {
    logic start;    // load the walk position from the cursor
    logic advance;  // step to the next lamp
  } slul_walk_ctrl_t;

  // Walk status back to the sequencer
  typedef struct packed {
    logic hit;      // lamp at the walk position differs from its request
    logic last;     // walk position is the final lamp of this pass
  } slul_walk_stat_t;

  // Word bit that carries the lamp at a given walk index:
  // P1 lamps, P2 lamps, then the spare word bits in ascending order
  function automatic logic [BIT_SEL_W-1:0] walk_bit(input logic [BIT_SEL_W-1:0] idx);
    logic [BIT_SEL_W-1:0] b;
    unique case (idx)
      5'd0:  b = 5'd25;
      5'd1:  b = 5'd28;
      5'd2:  b = 5'd27;
      5'd3:  b = 5'd26;
      5'd4:  b = 5'd29;
      5'd5:  b = 5'd9;
      5'd6:  b = 5'd12;
      5'd7:  b = 5'd11;
      5'd8:  b = 5'd10;
      5'd9:  b = 5'd13;
      5'd10: b = 5'd0;
      5'd11: b = 5'd1;
      5'd12: b = 5'd2;
      5'd13: b = 5'd3;
      5'd14: b = 5'd4;
      5'd15: b = 5'd5;
      5'd16: b = 5'd6;
      5'd17: b = 5'd7;
      5'd18: b = 5'd8;
      5'd19: b = 5'd14;
      5'd20: b = 5'd15;
      5'd21: b = 5'd16;
      5'd22: b = 5'd17;
      5'd23: b = 5'd18;
      5'd24: b = 5'd19;
      5'd25: b = 5'd20;
      5'd26: b = 5'd21;
      5'd27: b = 5'd22;
      5'd28: b = 5'd23;
      5'd29: b = 5'd24;
      5'd30: b = 5'd30;
      default: b = 5'd31;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/slul_walk.sv
// ----------------------------------------------------------------------------
// slul_walk
// Round-robin lamp walker: one lamp compared against its request per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slul_walk #(
  parameter int LAMPS = slul_pkg::LAMPS_DEF,
  parameter int IDX_W = (LAMPS > 1) ? $clog2(LAMPS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire slul_pkg::slul_walk_ctrl_t     ctrl,
  input  wire logic [IDX_W-1:0]              start_idx,
  input  wire logic [slul_pkg::WORD_W-1:0]   word,
  input  wire logic [LAMPS-1:0]              latched,
  output slul_pkg::slul_walk_stat_t          stat,
  output logic [IDX_W-1:0]                   idx,
  output logic [IDX_W-1:0]                   idx_next
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LAMPS - 1);

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] cnt_r;
  logic [slul_pkg::BIT_SEL_W-1:0] sel;

  // Position after the current lamp, wrapping at the lamp count
  always_comb begin
    if (idx_r == IDX_LAST) begin
      idx_next = '0;
    end else begin
      idx_next = idx_r + 1'b1;
    end
  end

  // Walk position and pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
    end else if (ctrl.start) begin
      idx_r <= start_idx;
      cnt_r <= '0;
    end else if (ctrl.advance) begin
      idx_r <= idx_next;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Compare requested bit against latched bit at the walk position
  assign sel       = slul_pkg::walk_bit(slul_pkg::BIT_SEL_W'(idx_r));
  assign stat.hit  = word[sel] != latched[idx_r];
  assign stat.last = cnt_r == IDX_LAST;
  assign idx       = idx_r;

endmodule

`default_nettype wire

>>> rtl/staggered_lamp_update_limiter_core.sv
// A request accepted while the change countdown runs goes to the refresh check;
// with the countdown expired a lamp walk is made first (one lamp per cycle).
// The input is not ready while a request is in work; a finished result waits
// in the output register. Reset (rst_n low, synchronous) turns all lamps off,
// clears cursor, countdown and frame time, and loads register defaults.
// ----------------------------------------------------------------------------
// staggered_lamp_update_limiter_core
// Switches at most one lamp per change interval, round-robin, and resends
// the unchanged lamp frame when the refresh period passes without a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module staggered_lamp_update_limiter_core #(
  parameter int LAMPS = slul_pkg::LAMPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [slul_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [slul_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Request channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [63:0]                       in_tdata,   // lights_word, now_ms
  // Result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [15:0]                            out_tdata,  // lamp_frame, zero pad
  output logic [0:0]                             out_tuser   // is_refresh
);

  localparam int IDX_W   = (LAMPS > 1) ? $clog2(LAMPS) : 1;
  localparam int WORD_W  = slul_pkg::WORD_W;
  localparam int TIME_W  = slul_pkg::TIME_W;
  localparam int FRAME_W = slul_pkg::FRAME_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CHECK,
    ST_EMIT
  } state_t;

  state_t                              state_r;
  logic [slul_pkg::INTERVAL_W-1:0]     interval_r;
  logic [slul_pkg::PERIOD_W-1:0]       period_r;
  logic [LAMPS-1:0]                    latched_r;
  logic [IDX_W-1:0]                    cursor_r;
  logic [slul_pkg::INTERVAL_W-1:0]     delay_r;
  logic [TIME_W-1:0]                   last_time_r;
  logic [WORD_W-1:0]                   word_r;
  logic [TIME_W-1:0]                   now_r;
  logic                                pend_refresh_r;
  logic                                out_valid_r;
  logic [FRAME_W-1:0]                  out_frame_r;
  logic                                out_refresh_r;

  logic                                in_fire;
  logic                                slot_free;
  logic [TIME_W-1:0]                   elapsed;
  logic [FRAME_W+LAMPS-1:0]            frame_ext;
  slul_pkg::slul_walk_ctrl_t           walk_ctrl;
  slul_pkg::slul_walk_stat_t           walk_stat;
  logic [IDX_W-1:0]                    walk_idx;
  logic [IDX_W-1:0]                    walk_idx_next;

  assign in_tready = state_r == ST_IDLE;
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign elapsed   = now_r - last_time_r;
  assign frame_ext = {{FRAME_W{1'b0}}, latched_r};

  // Walk starts on a request with the countdown expired
  assign walk_ctrl.start   = in_fire && (delay_r == '0);
  assign walk_ctrl.advance = (state_r == ST_WALK) && !walk_stat.hit && !walk_stat.last;

  slul_walk #(
    .LAMPS (LAMPS),
    .IDX_W (IDX_W)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (walk_ctrl),
    .start_idx (cursor_r),
    .word      (in_fire ? in_tdata[WORD_W-1:0] : word_r),
    .latched   (latched_r),
    .stat      (walk_stat),
    .idx       (walk_idx),
    .idx_next  (walk_idx_next)
  );

  // Sequencer, lamp state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      interval_r     <= slul_pkg::INTERVAL_RST;
      period_r       <= slul_pkg::PERIOD_RST;
      latched_r      <= '0;
      cursor_r       <= '0;
      delay_r        <= '0;
      last_time_r    <= '0;
      pend_refresh_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      // Register writes
      if (cfg_we) begin
        unique case (cfg_addr)
          slul_pkg::CFG_CHANGE_INTERVAL:
            interval_r <= cfg_wdata[slul_pkg::INTERVAL_W-1:0];
          slul_pkg::CFG_REFRESH_PERIOD:
            period_r   <= cfg_wdata[slul_pkg::PERIOD_W-1:0];
          default: ;
        endcase
      end

      // Output drains; the emit state reloads it itself
      if (out_tready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            word_r <= in_tdata[WORD_W-1:0];
            now_r  <= in_tdata[WORD_W+TIME_W-1:WORD_W];
            if (delay_r != '0) begin
              delay_r <= delay_r - 1'b1;
              state_r <= ST_CHECK;
            end else begin
              state_r <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          // Switch the first differing lamp, else fall to the refresh check
          if (walk_stat.hit) begin
            latched_r[walk_idx] <= ~latched_r[walk_idx];
            cursor_r            <= walk_idx_next;
            delay_r             <= interval_r - 1'b1;
            last_time_r         <= now_r;
            pend_refresh_r      <= 1'b0;
            state_r             <= ST_EMIT;
          end else if (walk_stat.last) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // Resend when the refresh period has passed, modulo 2^32
          if (elapsed >= TIME_W'(period_r)) begin
            last_time_r    <= now_r;
            pend_refresh_r <= 1'b1;
            state_r        <= ST_EMIT;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_r   <= 1'b1;
            out_frame_r   <= frame_ext[FRAME_W-1:0];
            out_refresh_r <= pend_refresh_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - FRAME_W){1'b0}}, out_frame_r};
  assign out_tuser  = out_refresh_r;

endmodule

`default_nettype wire
